// ===== rtl/core/timer_prescaler_compare_finder_defines.svh =====
// ----------------------------------------------------------------------------
// Timer prescaler finder assertion macros
// Shared concurrent assertion shorthands for the prescaler finder checkers.
// ----------------------------------------------------------------------------
`ifndef TIMER_PRESCALER_COMPARE_FINDER_DEFINES_SVH
`define TIMER_PRESCALER_COMPARE_FINDER_DEFINES_SVH

// Clocked assertion that is switched off while reset is applied.
`define TPCF_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that is also checked while reset is applied.
`define TPCF_ASSERT_NR(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/tpcf_pkg.sv =====
// ----------------------------------------------------------------------------
// Timer prescaler finder package
// Widths, constants, prescaler shift tables and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package tpcf_pkg;

  // Field widths.
  localparam int REQ_W   = 26;
  localparam int SEL_W   = 2;
  localparam int CODE_W  = 3;
  localparam int CMP_W   = 16;
  localparam int ACT_W   = 26;
  localparam int HZ_W    = 27;
  localparam int SHIFT_W = 4;

  localparam int NUM_CODES   = 1 << CODE_W;
  localparam int NARROW_BITS = 8;
  localparam int MAX_SHIFT   = 10;

  // Time is counted in units of 1/120 microsecond.
  localparam int UNITS_PER_US = 120;
  localparam logic [HZ_W-1:0] UNITS_PER_SEC = HZ_W'(120000000);
  localparam logic [HZ_W-1:0] HZ_RESET      = HZ_W'(8000000);

  // Internal widths.
  localparam int Q_W   = HZ_W;              // CPU tick length in units
  localparam int X_W   = REQ_W + 7;         // requested period in units
  localparam int LIM_W = Q_W + CMP_W;       // compare limit times tick length
  localparam int THR_W = LIM_W + MAX_SHIFT; // limit scaled by the prescaler
  localparam int Y_W   = CMP_W + Q_W;       // ticks times tick length
  localparam int Z_W   = Y_W + MAX_SHIFT - 3;
  localparam int V_W   = 30;

  // Values that belong to the reset clock.
  localparam int Q_RESET_INT = 120000000 / 8000000;
  localparam logic [Q_W-1:0]   Q_RESET          = Q_W'(Q_RESET_INT);
  localparam logic [LIM_W-1:0] LIM_WIDE_RESET   =
    LIM_W'(Q_RESET_INT * ((1 << CMP_W) - 1));
  localparam logic [LIM_W-1:0] LIM_NARROW_RESET =
    LIM_W'(Q_RESET_INT * ((1 << NARROW_BITS) - 1));

  // Division by 15 through a reciprocal, exact for operands below 2^30.
  localparam int RECIP_W     = 31;
  localparam int RECIP_SHIFT = 34;
  localparam logic [RECIP_W-1:0] RECIP_15 = RECIP_W'(1145324613);
  localparam logic [Z_W-1:0] SAT_LIMIT = Z_W'(15) << ACT_W;
  localparam logic [ACT_W-1:0] ACT_MAX = '1;

  // Prescaler shifts by clock-select code; NO_SHIFT marks an unusable code.
  localparam logic [SHIFT_W-1:0] NO_SHIFT = '1;
  localparam logic [SHIFT_W-1:0] COARSE_SHIFT [NUM_CODES] =
    '{NO_SHIFT, 4'd0, 4'd3, 4'd6, 4'd8, 4'd10, NO_SHIFT, NO_SHIFT};
  localparam logic [SHIFT_W-1:0] FINE_SHIFT [NUM_CODES] =
    '{NO_SHIFT, 4'd0, 4'd3, 4'd5, 4'd6, 4'd7, 4'd8, 4'd10};

  typedef enum logic [SEL_W-1:0] {
    TMR_NARROW = 2'd0,
    TMR_WIDE   = 2'd1,
    TMR_FINE   = 2'd2,
    TMR_NONE   = 2'd3
  } tmr_sel_e;

  typedef enum logic [2:0] {
    QC_IDLE = 3'b001,
    QC_DIV  = 3'b010,
    QC_LIM  = 3'b100
  } qc_state_e;

  // Clock-derived quantities, held stable between configuration writes.
  typedef struct packed {
    logic [Q_W-1:0]   q;
    logic [LIM_W-1:0] lim_wide;
    logic [LIM_W-1:0] lim_narrow;
  } clk_info_t;

  // Per-transaction control that rides alongside the divider.
  typedef struct packed {
    logic               found;
    logic [CODE_W-1:0]  code;
    logic [SHIFT_W-1:0] shift;
  } side_t;

endpackage

`default_nettype wire

// ===== rtl/core/tpcf_if.sv =====
// ----------------------------------------------------------------------------
// Timer prescaler finder channels
// Request and response valid/ready channels with their payloads.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpcf_req_if;
  logic                       valid;
  logic                       ready;
  logic [tpcf_pkg::REQ_W-1:0] req_us;
  logic [tpcf_pkg::SEL_W-1:0] timer_select;

  modport source (output valid, req_us, timer_select, input ready);
  modport sink (input valid, req_us, timer_select, output ready);
endinterface

interface tpcf_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        found;
  logic [tpcf_pkg::CODE_W-1:0] prescale_select;
  logic [tpcf_pkg::CMP_W-1:0]  compare_value;
  logic [tpcf_pkg::ACT_W-1:0]  actual_us;

  modport source (output valid, found, prescale_select, compare_value, actual_us,
                  input ready);
  modport sink (input valid, found, prescale_select, compare_value, actual_us,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/tpcf_qcalc.sv =====
// ----------------------------------------------------------------------------
// Timer prescaler finder clock unit
// Holds the CPU clock and derives the tick length and compare limits from it.
// ----------------------------------------------------------------------------
`default_nettype none

module tpcf_qcalc (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [tpcf_pkg::HZ_W-1:0] cfg_wdata_i,
  output logic                      busy_o,
  output tpcf_pkg::clk_info_t       info_o
);

  localparam int STEPS = tpcf_pkg::HZ_W;
  localparam int CNT_W = $clog2(STEPS);

  tpcf_pkg::qc_state_e state_q, state_d;
  logic [tpcf_pkg::HZ_W-1:0] div_q;
  logic [tpcf_pkg::HZ_W-1:0] num_q, num_d;
  logic [tpcf_pkg::HZ_W-1:0] rem_q, rem_d;
  logic [tpcf_pkg::Q_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  tpcf_pkg::clk_info_t       info_q, info_d;

  logic [tpcf_pkg::HZ_W:0]   rem_sh;
  logic                      ge;
  logic [tpcf_pkg::Q_W-1:0]  q_fin;

  // One quotient bit per cycle, restoring.
  assign rem_sh = {rem_q, num_q[tpcf_pkg::HZ_W-1]};
  assign ge     = rem_sh >= {1'b0, div_q};
  // A zero clock yields no tick length at all.
  assign q_fin  = (div_q == '0) ? '0 : quo_q;

  always_comb begin
    state_d = state_q;
    num_d   = num_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    info_d  = info_q;
    case (state_q)
      tpcf_pkg::QC_IDLE: begin
      end
      tpcf_pkg::QC_DIV: begin
        num_d = num_q << 1;
        rem_d = ge ? tpcf_pkg::HZ_W'(rem_sh - {1'b0, div_q})
                   : tpcf_pkg::HZ_W'(rem_sh);
        quo_d = {quo_q[tpcf_pkg::Q_W-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(STEPS - 1)) begin
          state_d = tpcf_pkg::QC_LIM;
        end
      end
      tpcf_pkg::QC_LIM: begin
        info_d.q          = q_fin;
        info_d.lim_wide   = (tpcf_pkg::LIM_W'(q_fin) << tpcf_pkg::CMP_W)
                            - tpcf_pkg::LIM_W'(q_fin);
        info_d.lim_narrow = (tpcf_pkg::LIM_W'(q_fin) << tpcf_pkg::NARROW_BITS)
                            - tpcf_pkg::LIM_W'(q_fin);
        state_d           = tpcf_pkg::QC_IDLE;
      end
      default: begin
        state_d = tpcf_pkg::QC_IDLE;
      end
    endcase
    // A new write restarts the division whatever is under way.
    if (cfg_we_i) begin
      state_d = tpcf_pkg::QC_DIV;
      num_d   = tpcf_pkg::UNITS_PER_SEC;
      rem_d   = '0;
      quo_d   = '0;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpcf_pkg::QC_IDLE;
      info_q  <= '{q:          tpcf_pkg::Q_RESET,
                   lim_wide:   tpcf_pkg::LIM_WIDE_RESET,
                   lim_narrow: tpcf_pkg::LIM_NARROW_RESET};
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      info_q  <= info_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cfg_we_i) begin
      div_q <= cfg_wdata_i;
    end
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign busy_o = state_q != tpcf_pkg::QC_IDLE;
  assign info_o = info_q;

endmodule

`default_nettype wire

// ===== rtl/core/tpcf_divider.sv =====
// ----------------------------------------------------------------------------
// Timer prescaler finder tick divider
// Pipelined restoring divider, one quotient bit per stage, with side data.
// ----------------------------------------------------------------------------
`default_nettype none

module tpcf_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [tpcf_pkg::Q_W-1:0]   q_i,
  input  logic                       up_valid_i,
  output logic                       up_ready_o,
  input  logic [tpcf_pkg::X_W-1:0]   up_dividend_i,
  input  tpcf_pkg::side_t            up_side_i,
  output logic                       dn_valid_o,
  input  logic                       dn_ready_i,
  output logic [tpcf_pkg::CMP_W-1:0] dn_quot_o,
  output tpcf_pkg::side_t            dn_side_o
);

  localparam int N     = tpcf_pkg::CMP_W;
  localparam int IDX_W = $clog2(N);
  localparam int DIV_W = tpcf_pkg::Q_W + N;

  typedef struct packed {
    logic [tpcf_pkg::X_W-1:0] rem;
    logic [N-1:0]             quo;
    tpcf_pkg::side_t          side;
  } stage_t;

  logic [N-1:0] valid_q;
  stage_t       stage_q [N];
  logic [N-1:0] cur_v;
  stage_t       cur_s [N];
  stage_t       nxt_s [N];
  logic [N-1:0] adv;

  always_comb begin
    cur_v[0] = up_valid_i;
    cur_s[0] = '{rem: up_dividend_i, quo: '0, side: up_side_i};
    for (int k = 1; k < N; k++) begin
      cur_v[k] = valid_q[k-1];
      cur_s[k] = stage_q[k-1];
    end
  end

  // Stage k decides quotient bit N-1-k.
  always_comb begin
    logic [DIV_W-1:0] dsr;
    for (int k = 0; k < N; k++) begin
      dsr      = DIV_W'(q_i) << (N - 1 - k);
      nxt_s[k] = cur_s[k];
      if (DIV_W'(cur_s[k].rem) >= dsr) begin
        nxt_s[k].rem = tpcf_pkg::X_W'(DIV_W'(cur_s[k].rem) - dsr);
        nxt_s[k].quo[IDX_W'(N - 1 - k)] = 1'b1;
      end
    end
  end

  // A stage loads when some stage at or after it is empty, or the sink takes.
  always_comb begin
    for (int k = 0; k < N; k++) begin
      adv[k] = dn_ready_i || (|(~valid_q & (N'({N{1'b1}}) << k)));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < N; k++) begin
        if (adv[k]) begin
          valid_q[k] <= cur_v[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < N; k++) begin
      if (adv[k] && cur_v[k]) begin
        stage_q[k] <= nxt_s[k];
      end
    end
  end

  assign up_ready_o = adv[0];
  assign dn_valid_o = valid_q[N-1];
  assign dn_quot_o  = stage_q[N-1].quo;
  assign dn_side_o  = stage_q[N-1].side;

endmodule

`default_nettype wire

// ===== rtl/core/timer_prescaler_compare_finder.sv =====
// ----------------------------------------------------------------------------
// Timer prescaler and compare value finder
// Picks the first prescaler whose tick count fits the chosen timer and
// returns the clock-select code, the compare value and the achieved period.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake        Payload
//   in_ch     sink       valid / ready    req_us, timer_select
//   out_ch    source     valid / ready    found, prescale_select,
//                                         compare_value, actual_us
//   cfg       sink       cfg_we_i         cfg_wdata_i (CPU clock in hertz)
//
// One transaction enters per cycle unless the output or the clock unit holds
// it off; each result passes in order through the input stage, prescaler
// selection, 16 divider stages (one quotient bit each), product, shift and
// saturation, output register. A clock write divides the unit rate by the
// clock bit-serially, then redoes the limits, with in_ch.ready low meanwhile.
// Reset is asynchronous and active low; tick length and limits return to 8 MHz.
// Each stage holds only while every stage behind it is full and the output
// waits, so bubbles close up under a stalled output and nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module timer_prescaler_compare_finder (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [tpcf_pkg::HZ_W-1:0] cfg_wdata_i,
  tpcf_req_if.sink                  in_ch,
  tpcf_rsp_if.source                out_ch
);

  // --------------------------------------------------------------------------
  // Clock register and derived tick length.
  // --------------------------------------------------------------------------
  logic                qc_busy;
  tpcf_pkg::clk_info_t info;

  tpcf_qcalc u_qcalc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .busy_o      (qc_busy),
    .info_o      (info)
  );

  // --------------------------------------------------------------------------
  // Stage advance terms. Every stage loads when it is empty or the stage after
  // it loads, so a stall only backs up as far as the first bubble.
  // --------------------------------------------------------------------------
  logic adv_0, adv_1, adv_m, adv_z, adv_o;
  logic div_up_ready;
  logic in_accept;

  logic v0_q, v1_q, vm_q, vz_q, vo_q;
  logic div_v;

  assign adv_o = !vo_q || out_ch.ready;
  assign adv_z = !vz_q || adv_o;
  assign adv_m = !vm_q || adv_z;
  assign adv_1 = !v1_q || div_up_ready;
  assign adv_0 = !v0_q || adv_1;

  // New requests are held off while the clock unit recomputes.
  assign in_ch.ready = adv_0 && !qc_busy;
  assign in_accept   = in_ch.valid && in_ch.ready;

  // --------------------------------------------------------------------------
  // Input stage: the request converted to 1/120 us units (times 128 minus
  // times 8).
  // --------------------------------------------------------------------------
  logic [tpcf_pkg::X_W-1:0] x0_q;
  tpcf_pkg::tmr_sel_e       sel0_q;

  always_ff @(posedge clk_i) begin
    if (adv_0 && in_accept) begin
      x0_q   <= (tpcf_pkg::X_W'(in_ch.req_us) << 7) - (tpcf_pkg::X_W'(in_ch.req_us) << 3);
      sel0_q <= tpcf_pkg::tmr_sel_e'(in_ch.timer_select);
    end
  end

  // --------------------------------------------------------------------------
  // Prescaler selection. A code fits when the request is shorter than the
  // compare limit times the prescaled tick, which is the same as saying the
  // truncated tick count plus one stays within the timer's width. The lowest
  // fitting code wins. A zero tick length gives zero limits, so nothing fits;
  // the unused timer select never fits either.
  // --------------------------------------------------------------------------
  logic                           sel_fine;
  logic [tpcf_pkg::LIM_W-1:0]     sel_lim;
  logic [tpcf_pkg::SHIFT_W-1:0]   code_sh [tpcf_pkg::NUM_CODES];
  logic [tpcf_pkg::NUM_CODES-1:0] fit;
  tpcf_pkg::side_t                pick;

  assign sel_fine = sel0_q == tpcf_pkg::TMR_FINE;
  assign sel_lim  = (sel0_q == tpcf_pkg::TMR_WIDE) ? info.lim_wide : info.lim_narrow;

  always_comb begin
    for (int c = 0; c < tpcf_pkg::NUM_CODES; c++) begin
      code_sh[c] = sel_fine ? tpcf_pkg::FINE_SHIFT[c] : tpcf_pkg::COARSE_SHIFT[c];
      fit[c]     = (code_sh[c] != tpcf_pkg::NO_SHIFT)
                   && (sel0_q != tpcf_pkg::TMR_NONE)
                   && (tpcf_pkg::THR_W'(x0_q) < (tpcf_pkg::THR_W'(sel_lim) << code_sh[c]));
    end
  end

  always_comb begin
    pick = '0;
    for (int c = tpcf_pkg::NUM_CODES - 1; c >= 1; c--) begin
      if (fit[c]) begin
        pick.found = 1'b1;
        pick.code  = tpcf_pkg::CODE_W'(c);
        pick.shift = code_sh[c];
      end
    end
  end

  // The prescaled division floor(x / (q << s)) is done as floor((x >> s) / q).
  logic [tpcf_pkg::X_W-1:0] d1_q;
  tpcf_pkg::side_t          side1_q;

  always_ff @(posedge clk_i) begin
    if (adv_1 && v0_q) begin
      d1_q    <= x0_q >> pick.shift;
      side1_q <= pick;
    end
  end

  // --------------------------------------------------------------------------
  // Tick count division.
  // --------------------------------------------------------------------------
  logic [tpcf_pkg::CMP_W-1:0] div_quot;
  tpcf_pkg::side_t            div_side;

  tpcf_divider u_divider (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_i           (info.q),
    .up_valid_i    (v1_q),
    .up_ready_o    (div_up_ready),
    .up_dividend_i (d1_q),
    .up_side_i     (side1_q),
    .dn_valid_o    (div_v),
    .dn_ready_i    (adv_m),
    .dn_quot_o     (div_quot),
    .dn_side_o     (div_side)
  );

  // --------------------------------------------------------------------------
  // Achieved period: floor(ticks * q * 2^s / 120). The tick count times q is
  // registered first, then shifted and divided by 8, then divided by 15
  // through a reciprocal multiply. Anything at or above 15 * 2^26 after the
  // divide by 8 would exceed the 26-bit result and saturates.
  // --------------------------------------------------------------------------
  logic [tpcf_pkg::CMP_W-1:0] ticks;
  logic [tpcf_pkg::Y_W-1:0]   ym_q;
  logic [tpcf_pkg::CMP_W-1:0] tm_q;
  tpcf_pkg::side_t            sidem_q;

  assign ticks = div_quot + 1'b1;

  always_ff @(posedge clk_i) begin
    if (adv_m && div_v) begin
      ym_q    <= tpcf_pkg::Y_W'(ticks) * tpcf_pkg::Y_W'(info.q);
      tm_q    <= ticks;
      sidem_q <= div_side;
    end
  end

  logic [tpcf_pkg::THR_W-1:0] y_sh;
  logic [tpcf_pkg::Z_W-1:0]   z_val;
  logic [tpcf_pkg::V_W-1:0]   vz_val_q;
  logic                       satz_q;
  logic [tpcf_pkg::CMP_W-1:0] tz_q;
  tpcf_pkg::side_t            sidez_q;

  assign y_sh  = tpcf_pkg::THR_W'(ym_q) << sidem_q.shift;
  assign z_val = tpcf_pkg::Z_W'(y_sh >> 3);

  always_ff @(posedge clk_i) begin
    if (adv_z && vm_q) begin
      vz_val_q <= z_val[tpcf_pkg::V_W-1:0];
      satz_q   <= z_val >= tpcf_pkg::SAT_LIMIT;
      tz_q     <= tm_q;
      sidez_q  <= sidem_q;
    end
  end

  localparam int P_W = tpcf_pkg::V_W + tpcf_pkg::RECIP_W;

  logic [P_W-1:0]             recip_prod;
  logic [tpcf_pkg::ACT_W-1:0] act_val;

  assign recip_prod = P_W'(vz_val_q) * P_W'(tpcf_pkg::RECIP_15);
  assign act_val    = satz_q ? tpcf_pkg::ACT_MAX
                             : recip_prod[tpcf_pkg::RECIP_SHIFT +: tpcf_pkg::ACT_W];

  // --------------------------------------------------------------------------
  // Output register. A miss reports all fields zero.
  // --------------------------------------------------------------------------
  logic                        found_q;
  logic [tpcf_pkg::CODE_W-1:0] code_q;
  logic [tpcf_pkg::CMP_W-1:0]  cmp_q;
  logic [tpcf_pkg::ACT_W-1:0]  act_q;

  always_ff @(posedge clk_i) begin
    if (adv_o && vz_q) begin
      found_q <= sidez_q.found;
      code_q  <= sidez_q.found ? sidez_q.code : '0;
      cmp_q   <= sidez_q.found ? tz_q : '0;
      act_q   <= sidez_q.found ? act_val : '0;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      vm_q <= 1'b0;
      vz_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (adv_0) begin
        v0_q <= in_accept;
      end
      if (adv_1) begin
        v1_q <= v0_q;
      end
      if (adv_m) begin
        vm_q <= div_v;
      end
      if (adv_z) begin
        vz_q <= vm_q;
      end
      if (adv_o) begin
        vo_q <= vz_q;
      end
    end
  end

  assign out_ch.valid           = vo_q;
  assign out_ch.found           = found_q;
  assign out_ch.prescale_select = code_q;
  assign out_ch.compare_value   = cmp_q;
  assign out_ch.actual_us       = act_q;

endmodule

`default_nettype wire

// ===== rtl/core/tpcf_checker.sv =====
// ----------------------------------------------------------------------------
// Timer prescaler finder checker
// Port-level assertions on the finder, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "timer_prescaler_compare_finder_defines.svh"

module tpcf_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       cfg_we_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic                       out_found_i,
  input logic [tpcf_pkg::CODE_W-1:0] out_sel_i,
  input logic [tpcf_pkg::CMP_W-1:0] out_cmp_i,
  input logic [tpcf_pkg::ACT_W-1:0] out_act_i
);

  // A clock write always blocks new requests while the tick length is redone.
  `TPCF_ASSERT(a_cfg_blocks_input, clk_i, rst_ni, cfg_we_i |=> !in_ready_i, "request taken during clock update")

  // A miss carries no code, count or period.
  `TPCF_ASSERT(a_miss_zero, clk_i, rst_ni, (out_valid_i && !out_found_i) |-> (out_sel_i == '0 && out_cmp_i == '0 && out_act_i == '0), "miss with nonzero fields")

  // A hit names a real clock-select code and at least one tick.
  `TPCF_ASSERT(a_hit_nonzero, clk_i, rst_ni, (out_valid_i && out_found_i) |-> (out_sel_i != '0 && out_cmp_i != '0), "hit with empty code or count")

  // A result that waits stays put.
  `TPCF_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_found_i) && $stable(out_sel_i) && $stable(out_cmp_i) && $stable(out_act_i)), "stalled result changed")

  // No result is offered while reset is applied.
  `TPCF_ASSERT_NR(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_i, "result valid in reset")

endmodule

bind timer_prescaler_compare_finder tpcf_checker u_tpcf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .in_ready_i  (in_ch.ready),
  .out_valid_i (out_ch.valid),
  .out_ready_i (out_ch.ready),
  .out_found_i (out_ch.found),
  .out_sel_i   (out_ch.prescale_select),
  .out_cmp_i   (out_ch.compare_value),
  .out_act_i   (out_ch.actual_us)
);

`default_nettype wire

// ===== tb/tb_timer_prescaler_compare_finder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Timer prescaler finder regression bench
// Drives period requests for all three timers under a series of CPU clock
// settings, predicts the clock-select code, compare value and achieved period
// of every request, and checks each response in order against that
// prediction while both channels idle and stall at random.
// ----------------------------------------------------------------------------

// One expected or observed response.
typedef struct packed {
  logic        found;
  logic [2:0]  code;
  logic [15:0] ticks;
  logic [25:0] period_us;
} timer_setting_t;

// Keeps its own copy of the CPU clock, works out the timer setting for every
// accepted request and compares the responses with those settings in order.
class prescaler_board;
  localparam byte unsigned NO_PRESCALE = 8'hff;
  localparam longint unsigned UNITS_PER_SECOND = 120000000;
  localparam longint unsigned UNITS_PER_MICRO = 120;
  localparam longint unsigned PERIOD_CEILING = (64'd1 << 26) - 64'd1;

  byte unsigned coarse_shift [8] = '{NO_PRESCALE, 0, 3, 6, 8, 10, NO_PRESCALE, NO_PRESCALE};
  byte unsigned fine_shift [8] = '{NO_PRESCALE, 0, 3, 5, 6, 7, 8, 10};

  longint unsigned clock_hz = 8000000;
  timer_setting_t expected_settings[$];
  int mismatch_count = 0;

  function void set_clock(logic [26:0] hz);
    clock_hz = hz;
  endfunction

  function int pending();
    return expected_settings.size();
  endfunction

  // The first usable prescaler, in ascending code order, whose tick count fits
  // the timer's compare width wins. All arithmetic is 64 bits wide.
  function timer_setting_t predict_setting(logic [25:0] req, logic [1:0] sel);
    timer_setting_t res;
    longint unsigned cpu_units, tick_units, req_units, tick_count, limit, achieved;
    byte unsigned shift;
    res = '0;
    if (sel == tpcf_pkg::TMR_NONE || clock_hz == 0) return res;
    cpu_units = UNITS_PER_SECOND / clock_hz;
    // A clock above 120 MHz leaves no whole unit per CPU tick.
    if (cpu_units == 0) return res;
    limit = (sel == tpcf_pkg::TMR_WIDE) ? 64'd65535 : 64'd255;
    req_units = req;
    req_units = req_units * UNITS_PER_MICRO;
    for (int code = 1; code < 8; code++) begin
      shift = (sel == tpcf_pkg::TMR_FINE) ? fine_shift[code] : coarse_shift[code];
      if (shift == NO_PRESCALE) continue;
      tick_units = cpu_units << shift;
      tick_count = req_units / tick_units + 64'd1;
      if (tick_count > limit) continue;
      achieved = (tick_count * tick_units) / UNITS_PER_MICRO;
      if (achieved > PERIOD_CEILING) achieved = PERIOD_CEILING;
      res.found = 1'b1;
      res.code = code[2:0];
      res.ticks = tick_count[15:0];
      res.period_us = achieved[25:0];
      return res;
    end
    return res;
  endfunction

  function void note_request(logic [25:0] req, logic [1:0] sel);
    expected_settings.push_back(predict_setting(req, sel));
  endfunction

  function void check_setting(logic found, logic [2:0] code, logic [15:0] ticks,
                              logic [25:0] period_us);
    timer_setting_t want;
    if (expected_settings.size() == 0) begin
      $error("response arrived with no request outstanding");
      mismatch_count++;
      return;
    end
    want = expected_settings.pop_front();
    if (found !== want.found) begin
      $error("found: expected %0d, actual %0d", want.found, found);
      mismatch_count++;
    end
    if (code !== want.code) begin
      $error("prescale_select: expected %0d, actual %0d", want.code, code);
      mismatch_count++;
    end
    if (ticks !== want.ticks) begin
      $error("compare_value: expected %0d, actual %0d", want.ticks, ticks);
      mismatch_count++;
    end
    if (period_us !== want.period_us) begin
      $error("actual_us: expected %0d, actual %0d", want.period_us, period_us);
      mismatch_count++;
    end
  endfunction
endclass

module tb_timer_prescaler_compare_finder;

  localparam int REQ_W = tpcf_pkg::REQ_W;
  localparam int SEL_W = tpcf_pkg::SEL_W;
  localparam int HZ_W  = tpcf_pkg::HZ_W;

  // Cycle ceiling for the whole run, set far beyond what a correct run needs
  // even with heavy stalls.
  localparam int CYCLE_LIMIT = 600000;
  // Extra wait after every request has been answered, before the bench
  // reprograms the clock and again at the end.
  localparam int SETTLE_CYCLES = 30;
  // Length of the long output stall used to back the pipeline up.
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 95;
  localparam int PRESSURE_ITEMS = 80;
  localparam int NUM_PHASES = 10;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [HZ_W-1:0] cfg_wdata_i;

  tpcf_req_if req_ch ();
  tpcf_rsp_if rsp_ch ();

  timer_prescaler_compare_finder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_ch      (req_ch),
    .out_ch     (rsp_ch)
  );

  prescaler_board board;

  // Random idling controls, changed from phase to phase by the main sequence.
  bit send_idle_on = 1'b1;
  bit rsp_idle_on = 1'b1;
  int send_gap_pct = 10;
  int rsp_stall_pct = 5;
  // Raised by the main sequence to ask the response side for one long stall.
  bit hold_output = 1'b0;
  int cycle_count = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Both channels are sampled at the rising edge, before any of the
  // nonblocking updates made at that edge take effect. A request accepted at
  // an edge is noted before the response check of the same edge; with the
  // block's latency the two can never belong together anyway.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_ch.valid && req_ch.ready)
        board.note_request(req_ch.req_us, req_ch.timer_select);
      if (rsp_ch.valid && rsp_ch.ready)
        board.check_setting(rsp_ch.found, rsp_ch.prescale_select,
                            rsp_ch.compare_value, rsp_ch.actual_us);
    end
  end

  // Response side. It either holds ready low for the long stall that the
  // main sequence asks for, counting the cycles itself, or stalls in short
  // random bursts, or simply keeps ready high.
  initial begin
    rsp_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_output) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_output = 1'b0;
        rsp_ch.ready <= 1'b1;
      end else if (rsp_idle_on && $urandom_range(0, 99) < rsp_stall_pct) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Offers one request, after an optional random gap, and returns at the edge
  // where it was taken. Valid stays high afterwards so that back-to-back
  // requests follow without a gap; stop_sending lowers it at the end of a batch.
  task automatic send_request(input logic [REQ_W-1:0] req, input logic [SEL_W-1:0] sel);
    if (send_idle_on && $urandom_range(0, 99) < send_gap_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_us <= req;
    req_ch.timer_select <= sel;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // Must be followed by something that waits for a clock edge, so that valid
  // is never lowered and raised again within one time step.
  task automatic stop_sending();
    req_ch.valid <= 1'b0;
  endtask

  // Sender pause: waits until every outstanding request has been answered.
  // The first edge is taken unconditionally so that a request accepted at the
  // current edge has already been noted when the count is looked at.
  task automatic wait_for_drain();
    do @(posedge clk_i); while (board.pending() > 0);
  endtask

  // Reprograms the CPU clock. Only called with nothing in flight.
  task automatic write_clock(input logic [HZ_W-1:0] hz);
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= hz;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_clock(hz);
  endtask

  // Random requests. Most periods are short or moderate, where the prescaler
  // choice and the compare boundaries live; some span the stated range and a
  // few the whole field. Timer select three shows up about one time in eight.
  task automatic send_random(input int count);
    logic [REQ_W-1:0] req;
    logic [SEL_W-1:0] sel;
    int pick;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: req = REQ_W'($urandom_range(0, 300));
        3, 4: req = REQ_W'($urandom_range(0, 70000));
        5, 6: req = REQ_W'($urandom_range(0, 9000000));
        7, 8: req = REQ_W'($urandom_range(0, 35791394));
        default: req = REQ_W'($urandom);
      endcase
      pick = $urandom_range(0, 7);
      sel = (pick == 7) ? SEL_W'(tpcf_pkg::TMR_NONE) : SEL_W'(pick % 3);
      send_request(req, sel);
    end
  endtask

  // Directed requests at the reset clock of 8 MHz, where one CPU tick is 15
  // units: zero and full-scale periods on every timer, the point where the
  // narrow timer moves from the undivided clock to the next prescaler, the
  // largest periods the narrow and wide timers can still reach, the first
  // ones they cannot, and alternating bit patterns.
  task automatic send_directed();
    send_request(REQ_W'(0), tpcf_pkg::TMR_NARROW);
    send_request(REQ_W'(0), tpcf_pkg::TMR_WIDE);
    send_request(REQ_W'(0), tpcf_pkg::TMR_FINE);
    send_request(REQ_W'(0), tpcf_pkg::TMR_NONE);
    send_request(REQ_W'(31), tpcf_pkg::TMR_NARROW);
    send_request(REQ_W'(32), tpcf_pkg::TMR_NARROW);
    send_request(REQ_W'(31), tpcf_pkg::TMR_FINE);
    send_request(REQ_W'(32), tpcf_pkg::TMR_FINE);
    send_request(REQ_W'(8191), tpcf_pkg::TMR_WIDE);
    send_request(REQ_W'(8192), tpcf_pkg::TMR_WIDE);
    send_request(REQ_W'(32639), tpcf_pkg::TMR_NARROW);
    send_request(REQ_W'(32640), tpcf_pkg::TMR_NARROW);
    send_request(REQ_W'(32639), tpcf_pkg::TMR_FINE);
    send_request(REQ_W'(40000), tpcf_pkg::TMR_FINE);
    send_request(REQ_W'(8388479), tpcf_pkg::TMR_WIDE);
    send_request(REQ_W'(8388480), tpcf_pkg::TMR_WIDE);
    send_request(REQ_W'(35791394), tpcf_pkg::TMR_NARROW);
    send_request(REQ_W'(35791394), tpcf_pkg::TMR_WIDE);
    send_request(REQ_W'(35791394), tpcf_pkg::TMR_FINE);
    send_request('1, tpcf_pkg::TMR_NARROW);
    send_request('1, tpcf_pkg::TMR_WIDE);
    send_request('1, tpcf_pkg::TMR_FINE);
    send_request('1, tpcf_pkg::TMR_NONE);
    send_request(REQ_W'(26'h2aaaaaa), tpcf_pkg::TMR_WIDE);
    send_request(REQ_W'(26'h1555555), tpcf_pkg::TMR_FINE);
  endtask

  initial begin
    logic [HZ_W-1:0] clock_plan [NUM_PHASES];

    board = new();
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    req_ch.valid <= 1'b0;
    req_ch.req_us <= '0;
    req_ch.timer_select <= '0;

    // Clock settings after the reset one: the ends of the supported range,
    // zero, the largest value the register holds, clocks just above 120 MHz
    // and far below 1 MHz (where the achieved period saturates), a few
    // random settings, and finally the reset value again.
    clock_plan[0] = HZ_W'(1000000);
    clock_plan[1] = HZ_W'(120000000);
    clock_plan[2] = '0;
    clock_plan[3] = '1;
    clock_plan[4] = HZ_W'(1);
    clock_plan[5] = HZ_W'(120000001);
    clock_plan[6] = HZ_W'($urandom_range(1000000, 120000000));
    clock_plan[7] = HZ_W'($urandom);
    clock_plan[8] = HZ_W'($urandom_range(1, 999999));
    clock_plan[9] = HZ_W'(8000000);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset clock: directed requests, then random ones.
    send_directed();
    send_random(PHASE_ITEMS);
    stop_sending();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_clock(clock_plan[p]);
      if (p == NUM_PHASES - 1) begin
        // The closing stretch runs with both sides at full rate.
        send_idle_on = 1'b0;
        rsp_idle_on = 1'b0;
      end else begin
        // Some phases run without idling on one side or the other.
        send_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        rsp_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(3, 15);
      end
      if (p == 0) begin
        // Back the pipeline up: the output stalls for a long stretch while
        // requests keep coming with no gaps, until the input stalls too.
        send_idle_on = 1'b0;
        hold_output = 1'b1;
        send_random(PRESSURE_ITEMS);
        send_idle_on = 1'b1;
      end
      if (p == 2) begin
        // Let the block run completely dry halfway through the phase.
        send_random(PHASE_ITEMS / 2);
        stop_sending();
        wait_for_drain();
        send_random(PHASE_ITEMS / 2);
      end else begin
        send_random(PHASE_ITEMS);
      end
      stop_sending();
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.mismatch_count == 0 && board.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
